FILE: rtl/wmf_pkg.sv
// windowed median filter: shared types and constants
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package wmf_pkg;

    localparam int PIX_W = 8;   // grey level width
    localparam int ROW_W = 11;  // row counters and frame height
    localparam int CFG_W = 11;  // widest configuration register
    localparam int RAD_W = 2;   // window radius register
    localparam int IDX_W = 2;   // configuration register index

    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // what one sorter cell shows to its right-hand neighbor
    typedef struct packed {
        logic             full;
        logic             less;
        logic [PIX_W-1:0] value;
    } cell_link_t;

endpackage

FILE: rtl/wmf_cell.sv
// windowed median filter: one cell of the insertion sorter chain
// depends on wmf_pkg
`timescale 1ns / 1ps

module wmf_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     ins_valid,
    input  logic [wmf_pkg::PIX_W-1:0] ins_value,
    input  wmf_pkg::cell_link_t      left,
    output wmf_pkg::cell_link_t      link
);

    logic                      full_reg;
    logic [wmf_pkg::PIX_W-1:0] value_reg;
    logic                      less;

    // an empty cell counts as holding +infinity
    assign less = !full_reg || (ins_value < value_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            full_reg <= 1'b0;
        end else if (ins_valid && less) begin
            if (left.less) begin
                full_reg <= left.full;
            end else begin
                full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_valid && less) begin
            // shift the left neighbor in, or take the new value at the insert point
            value_reg <= left.less ? left.value : ins_value;
        end
    end

    assign link.full  = full_reg;
    assign link.less  = less;
    assign link.value = value_reg;

endmodule

FILE: rtl/wmf_line_store.sv
// windowed median filter: circular line store, one write and one read port
// depends on wmf_pkg
`timescale 1ns / 1ps

module wmf_line_store #(
    parameter int DEPTH = 7168,
    parameter int PTR_W = 13
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [PTR_W-1:0]          wr_addr,
    input  logic [wmf_pkg::PIX_W-1:0] wr_data,
    input  logic [PTR_W-1:0]          rd_addr,
    output logic [wmf_pkg::PIX_W-1:0] rd_data
);

    logic [wmf_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/windowed_median_filter.sv
// windowed median filter top level: counters, window scan and sorter chain
// depends on wmf_pkg, wmf_cell, wmf_line_store
//
// Pixels enter on the s_ channel in raster order (tuser = 0) and flush ticks
// (tuser = 1) follow the last pixel to drain the rows still pending. Each
// pixel is written to a circular line store of MAX_WIDTH*(2*MAX_RADIUS+1)
// entries. Once R lines and R pixels are ahead of the output position, each
// transfer in yields one median on the m_ channel, raster order, tlast on the
// frame's final result. Pixels past the frame end are dropped.
// An item that yields no result is taken without leaving the idle state. One
// that yields a result runs a setup state, one line store read per window
// position (single read port), a drain state, and a state that hands the
// median to the output register; no new item is taken meanwhile. Each read
// value is inserted into a chain of (2*MAX_RADIUS+1)^2 sorter cells.
// The next item is taken while a result waits in the output register; a
// stalled receiver holds back only the next result. Reset (aresetn low,
// synchronous) clears counters and sets radius 1 and a 1024 x 1024 frame;
// no clearing pass is run. A configuration write restarts the frame.
`timescale 1ns / 1ps

module windowed_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] grey_level
    input  logic                      s_tuser,   // [0] kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [7:0] median_level
    output logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic [wmf_pkg::IDX_W-1:0] cfg_addr,
    input  logic [wmf_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int NCELL  = SIDE * SIDE;
    localparam int SIDE_W = $clog2(SIDE);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = COL_W + 1;
    localparam int DEPTH  = MAX_WIDTH * SIDE;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(NCELL + 1);
    localparam int SEL_W  = $clog2(NCELL);
    localparam int ROW_W  = wmf_pkg::ROW_W;
    localparam int PIX_W  = wmf_pkg::PIX_W;
    localparam int LIN_W  = ROW_W + WID_W;

    // configuration
    logic [wmf_pkg::RAD_W-1:0] radius_reg;
    logic [wmf_pkg::CFG_W-1:0] width_reg;
    logic [wmf_pkg::CFG_W-1:0] height_reg;
    logic [wmf_pkg::RAD_W-1:0] eff_r;
    logic [WID_W-1:0]          eff_w;
    logic [ROW_W-1:0]          eff_h;

    // positions
    logic [COL_W-1:0] in_col_reg, out_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, out_row_reg, in_row_next;
    logic [PTR_W-1:0] wr_ptr_reg, out_ptr_reg;
    logic [LIN_W-1:0] in_lin_next;

    // window scan
    wmf_pkg::state_t state_reg, state_next;
    logic [SIDE_W-1:0]            scan_i_reg, scan_j_reg;
    logic [PTR_W-1:0]             row_ptr_reg, col_ptr_reg;
    logic signed [ROW_W+1:0]      rr_reg;
    logic signed [COL_W+1:0]      cc_reg;
    logic signed [COL_W+1:0]      cc_start;
    logic                         rd_valid_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [PIX_W-1:0]             rd_data;
    logic                         tap_valid;
    logic [SIDE_W-1:0]            side_last;
    logic                         row_end;
    logic [PTR_W:0]               ptr_plus_w;
    logic [PTR_W-1:0]             row_ptr_step;
    logic [PTR_W:0]               start_diff;
    logic [PTR_W-1:0]             start_ptr;
    logic [PTR_W:0]               lag_off;

    // output
    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;

    logic accept, is_pixel, in_open, out_open, pix_emit, emit, push, out_last;
    logic clear_pos, cfg_hit;
    logic [PIX_W-1:0] median;

    assign eff_r = (radius_reg == '0) ? 2'd1 :
                   ((32'(radius_reg) > MAX_RADIUS) ? wmf_pkg::RAD_W'(MAX_RADIUS) : radius_reg);
    assign eff_w = (width_reg == '0) ? WID_W'(1) :
                   ((32'(width_reg) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(width_reg));
    assign eff_h = (height_reg == '0) ? ROW_W'(1) : height_reg;

    assign accept   = s_tvalid && s_tready;
    assign is_pixel = !s_tuser;
    assign in_open  = in_row_reg < eff_h;
    assign out_open = out_row_reg < eff_h;

    always_comb begin
        if ({1'b0, in_col_reg} + WID_W'(1) >= eff_w) begin
            in_col_next = '0;
            in_row_next = in_row_reg + ROW_W'(1);
        end else begin
            in_col_next = in_col_reg + COL_W'(1);
            in_row_next = in_row_reg;
        end
    end

    // linear input position past the lag r*w + r
    assign in_lin_next = LIN_W'(in_row_next) * LIN_W'(eff_w) + LIN_W'(in_col_next);
    assign pix_emit    = in_lin_next > LIN_W'(lag_off);
    assign emit = is_pixel ? (in_open && pix_emit && out_open) : (!in_open && out_open);

    assign out_last = (out_row_reg == eff_h - ROW_W'(1)) &&
                      ({1'b0, out_col_reg} == eff_w - WID_W'(1));
    assign push      = (state_reg == wmf_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    assign cfg_hit   = cfg_wr_en && (cfg_addr == wmf_pkg::REG_RADIUS ||
                       cfg_addr == wmf_pkg::REG_WIDTH || cfg_addr == wmf_pkg::REG_HEIGHT);
    assign clear_pos = cfg_hit || (push && out_last);

    assign s_tready = (state_reg == wmf_pkg::ST_IDLE);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 2'd1;
            width_reg  <= wmf_pkg::CFG_W'(1024);
            height_reg <= wmf_pkg::CFG_W'(1024);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                wmf_pkg::REG_RADIUS: radius_reg <= cfg_wdata[wmf_pkg::RAD_W-1:0];
                wmf_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                wmf_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input and output positions
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_pos) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            wr_ptr_reg  <= '0;
            out_ptr_reg <= '0;
        end else begin
            if (accept && is_pixel && in_open) begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (push) begin
                if ({1'b0, out_col_reg} + WID_W'(1) >= eff_w) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
                out_ptr_reg <= (32'(out_ptr_reg) == DEPTH - 1) ? '0 : out_ptr_reg + PTR_W'(1);
            end
        end
    end

    wmf_line_store #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && is_pixel && in_open),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata),
        .rd_addr (col_ptr_reg),
        .rd_data (rd_data)
    );

    // window start: out_ptr - (r*w + r), wrapped into the store
    assign lag_off    = (PTR_W+1)'(eff_r * eff_w) + (PTR_W+1)'(eff_r);
    assign start_diff = {1'b0, out_ptr_reg} - lag_off;
    assign start_ptr  = start_diff[PTR_W] ? PTR_W'(start_diff + (PTR_W+1)'(DEPTH))
                                          : start_diff[PTR_W-1:0];
    assign cc_start   = $signed({2'b00, out_col_reg}) - $signed((COL_W+2)'(eff_r));

    assign ptr_plus_w   = {1'b0, row_ptr_reg} + (PTR_W+1)'(eff_w);
    assign row_ptr_step = (ptr_plus_w >= (PTR_W+1)'(DEPTH)) ?
                          PTR_W'(ptr_plus_w - (PTR_W+1)'(DEPTH)) : ptr_plus_w[PTR_W-1:0];
    assign side_last    = SIDE_W'({eff_r, 1'b0});
    assign row_end      = (scan_j_reg == side_last);
    assign tap_valid    = (rr_reg >= 0) && (rr_reg < $signed({2'b00, eff_h})) &&
                          (cc_reg >= 0) && (cc_reg < $signed({1'b0, eff_w}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wmf_pkg::ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == wmf_pkg::ST_SCAN) && tap_valid;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wmf_pkg::ST_IDLE:  if (accept && emit) state_next = wmf_pkg::ST_SETUP;
            wmf_pkg::ST_SETUP: state_next = wmf_pkg::ST_SCAN;
            wmf_pkg::ST_SCAN:  if (row_end && scan_i_reg == side_last) begin
                state_next = wmf_pkg::ST_DRAIN;
            end
            wmf_pkg::ST_DRAIN: state_next = wmf_pkg::ST_DONE;
            wmf_pkg::ST_DONE:  if (push) state_next = wmf_pkg::ST_IDLE;
            default:           state_next = wmf_pkg::ST_IDLE;
        endcase
    end

    // scan counters and read addresses
    always_ff @(posedge aclk) begin
        if (state_reg == wmf_pkg::ST_SETUP) begin
            scan_i_reg  <= '0;
            scan_j_reg  <= '0;
            row_ptr_reg <= start_ptr;
            col_ptr_reg <= start_ptr;
            rr_reg      <= $signed({2'b00, out_row_reg}) - $signed((ROW_W+2)'(eff_r));
            cc_reg      <= cc_start;
        end else if (state_reg == wmf_pkg::ST_SCAN) begin
            if (row_end) begin
                scan_j_reg  <= '0;
                scan_i_reg  <= scan_i_reg + SIDE_W'(1);
                rr_reg      <= rr_reg + $signed((ROW_W+2)'(1));
                cc_reg      <= cc_start;
                row_ptr_reg <= row_ptr_step;
                col_ptr_reg <= row_ptr_step;
            end else begin
                scan_j_reg  <= scan_j_reg + SIDE_W'(1);
                cc_reg      <= cc_reg + $signed((COL_W+2)'(1));
                col_ptr_reg <= (32'(col_ptr_reg) == DEPTH - 1) ? '0 : col_ptr_reg + PTR_W'(1);
            end
        end
    end

    // sorter chain, cell 0 holds the smallest value
    wmf_pkg::cell_link_t links [NCELL];
    logic chain_clear;
    assign chain_clear = (state_reg == wmf_pkg::ST_SETUP);

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            wmf_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .clear     (chain_clear),
                .ins_valid (rd_valid_reg),
                .ins_value (rd_data),
                .left      ((g == 0) ? wmf_pkg::cell_link_t'('0) : links[(g == 0) ? 0 : g-1]),
                .link      (links[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (chain_clear) begin
            n_reg <= '0;
        end else if (rd_valid_reg) begin
            n_reg <= n_reg + CNT_W'(1);
        end
    end

    assign median = links[SEL_W'(n_reg >> 1)].value;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_data_reg <= median;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/wmf_checker.sv
// windowed median filter: port-level checks over time
// depends on no package; bound to windowed_median_filter
`timescale 1ns / 1ps

module wmf_port_checks (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [7:0]                m_tdata,
    input logic                      m_tlast
);

    // no result right after reset
    a_reset_quiet : assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result transfer offered right after reset");

    // the block is ready for input right after reset
    a_reset_ready : assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a stalled result stays offered
    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind windowed_median_filter wmf_port_checks u_wmf_port_checks (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

FILE: test/wmf_checker.sv
// windowed median filter checker: watches the pixel, result and register ports,
// predicts each median with its own line store and counters, compares in order
// depends on wmf_pkg
`timescale 1ns / 1ps

module wmf_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] grey_level
    input  logic                      s_tuser,   // [0] kind
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [7:0]                m_tdata,   // [7:0] median_level
    input  logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic [wmf_pkg::IDX_W-1:0] cfg_addr,
    input  logic [wmf_pkg::CFG_W-1:0] cfg_wdata,
    output int                        errors,
    output int                        pending
);

    localparam int LINE_MAX  = 1024;
    localparam int RAD_MAX   = 3;
    localparam int STORE_LEN = LINE_MAX * (2 * RAD_MAX + 1);

    typedef struct packed {
        logic [wmf_pkg::PIX_W-1:0] level;
        logic                      last;
    } median_t;

    logic [wmf_pkg::PIX_W-1:0] pixel_mem [STORE_LEN];
    logic [wmf_pkg::RAD_W-1:0] radius_reg;
    logic [wmf_pkg::CFG_W-1:0] width_reg, height_reg;
    int                        in_col, in_row, out_col, out_row;
    median_t                   median_q[$];
    int                        err_cnt;

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic logic [wmf_pkg::PIX_W-1:0] window_median(int row, int col, int w, int h,
                                                                int r);
        logic [wmf_pkg::PIX_W-1:0] vals [49];
        logic [wmf_pkg::PIX_W-1:0] v;
        int                        n;
        int                        k;
        n = 0;
        for (int rr = row - r; rr <= row + r; rr++) begin
            for (int cc = col - r; cc <= col + r; cc++) begin
                if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                    v = pixel_mem[(rr * w + cc) % STORE_LEN];
                    k = n;
                    while (k > 0 && vals[k-1] > v) begin
                        vals[k] = vals[k-1];
                        k--;
                    end
                    vals[k] = v;
                    n++;
                end
            end
        end
        return (n == 0) ? '0 : vals[n/2];
    endfunction

    // returns 1 when the transfer yields a median
    function automatic bit predict_median(logic kind, logic [wmf_pkg::PIX_W-1:0] grey,
                                          output median_t res);
        int  r, w, h, lag, total, in_lin, out_lin;
        bit  emit;
        r = (radius_reg == 0) ? 1 : int'(radius_reg);
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        lag     = r * w + r;
        total   = w * h;
        in_lin  = in_row * w + in_col;
        out_lin = out_row * w + out_col;
        emit    = 0;
        res     = '0;
        if (kind == 1'b0) begin
            if (in_lin < total) begin
                pixel_mem[in_lin % STORE_LEN] = grey;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
                in_lin++;
                emit = (in_lin > lag) && (out_lin < total);
            end
        end else begin
            emit = (in_lin >= total) && (out_lin < total);
        end
        if (emit) begin
            res.level = window_median(out_row, out_col, w, h, r);
            res.last  = (out_lin == total - 1);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            if (res.last)
                restart_frame();
        end
        return emit;
    endfunction

    always @(posedge aclk) begin
        median_t res;
        median_t want;
        if (!aresetn) begin
            radius_reg = 2'd1;
            width_reg  = 11'd1024;
            height_reg = 11'd1024;
            restart_frame();
            median_q.delete();
            err_cnt = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    wmf_pkg::REG_RADIUS: begin
                        radius_reg = cfg_wdata[wmf_pkg::RAD_W-1:0];
                        restart_frame();
                    end
                    wmf_pkg::REG_WIDTH: begin
                        width_reg = cfg_wdata;
                        restart_frame();
                    end
                    wmf_pkg::REG_HEIGHT: begin
                        height_reg = cfg_wdata;
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready && predict_median(s_tuser, s_tdata, res))
                median_q.push_back(res);
            if (m_tvalid && m_tready) begin
                if (median_q.size() == 0) begin
                    $error("median transfer with none expected: median_level %0d tlast %0b",
                           m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = median_q.pop_front();
                    if (m_tdata !== want.level) begin
                        $error("median_level: expected %0d, actual %0d", want.level, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_frame: expected %0b, actual %0b", want.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
        end
        errors  <= err_cnt;
        pending <= median_q.size();
    end

endmodule

FILE: test/tb_windowed_median_filter.sv
// windowed median filter testbench top: clock, reset, frame stimulus and verdict
// depends on wmf_pkg, windowed_median_filter and wmf_checker
`timescale 1ns / 1ps

module tb_windowed_median_filter;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid, s_tready, s_tuser;
    logic [7:0]                s_tdata;
    logic                      m_tvalid, m_tready, m_tlast;
    logic [7:0]                m_tdata;
    logic                      cfg_wr_en;
    logic [wmf_pkg::IDX_W-1:0] cfg_addr;
    logic [wmf_pkg::CFG_W-1:0] cfg_wdata;
    int                        errors, pending;

    int tx_idle, rx_idle;
    bit hold_req;
    bit held;
    int cycles;

    windowed_median_filter dut (.*);

    wmf_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // receiver: random stalls, plus a long hold-off whenever hold_req toggles
    always @(posedge aclk) begin
        static bit hold_seen = 0;
        static int hold_left = 0;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one transfer on the pixel channel, with random gaps in front
    task automatic send_item(logic kind, logic [7:0] grey);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= grey;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_frame_regs(int radius, int width, int height);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= wmf_pkg::REG_RADIUS;
        cfg_wdata <= wmf_pkg::CFG_W'(radius);
        @(posedge aclk);
        cfg_addr  <= wmf_pkg::REG_WIDTH;
        cfg_wdata <= wmf_pkg::CFG_W'(width);
        @(posedge aclk);
        cfg_addr  <= wmf_pkg::REG_HEIGHT;
        cfg_wdata <= wmf_pkg::CFG_W'(height);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // whole frame: pixels with optional stray flushes, sometimes a dropped pixel, then drain
    task automatic run_frame(int radius, int width, int height, bit noisy, output int sent);
        int r, w, h, total, lag, tail;
        r = (radius == 0) ? 1 : radius;
        w = (width == 0) ? 1 : ((width > 1024) ? 1024 : width);
        h = (height == 0) ? 1 : height;
        total = w * h;
        lag   = r * w + r;
        tail  = (lag < total) ? lag : total;
        sent  = 0;
        write_frame_regs(radius, width, height);
        for (int i = 0; i < total; i++) begin
            if (noisy && $urandom_range(99) < 4) begin
                send_item(1'b1, 8'($urandom));
                sent++;
            end
            send_item(1'b0, 8'($urandom));
            sent++;
        end
        // pixel past the frame end is dropped
        if (noisy && $urandom_range(3) == 0) begin
            send_item(1'b0, 8'($urandom));
            sent++;
        end
        for (int i = 0; i < tail; i++) begin
            send_item(1'b1, 8'($urandom));
            sent++;
        end
        wait_drained();
    endtask

    initial begin
        int sent, done_items;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = wmf_pkg::REG_RADIUS;
        cfg_wdata = '0;
        hold_req  = 0;
        held      = 0;
        tx_idle   = 0;
        rx_idle   = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset frame is 1024 x 1024: a few pixels and a flush give nothing
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b1, 8'd0);
        send_item(1'b0, 8'd128);
        wait_drained();

        // directed: 3x3 frame of extremes, radius zero treated as one
        write_frame_regs(0, 3, 3);
        send_item(1'b1, 8'd7);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd1);
        send_item(1'b0, 8'd254);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd9);
        repeat (4) send_item(1'b1, 8'd0);
        wait_drained();
        run_frame(0, 0, 0, 1'b0, sent);       // zero size treated as 1x1
        run_frame(3, 2, 2, 1'b1, sent);       // window larger than frame
        run_frame(2, 5, 1, 1'b1, sent);

        // narrow and wide shapes
        run_frame(3, 1, 40, 1'b0, sent);      // line narrower than the radius
        run_frame(1, 40, 2, 1'b0, sent);

        // random frames through three idle phases
        done_items = 0;
        tx_idle = 35;
        rx_idle = 69;
        while (done_items < 630) begin
            if (done_items >= 420) begin
                tx_idle = 0;
                rx_idle = 0;
            end else if (done_items >= 210) begin
                tx_idle = 69;
                rx_idle = 35;
            end
            if (done_items >= 450 && !held) begin
                hold_req <= !hold_req;
                held = 1;
            end
            if ($urandom_range(7) == 0)
                run_frame($urandom_range(3), $urandom_range(64), $urandom_range(4),
                          1'b1, sent);
            else
                run_frame($urandom_range(3), $urandom_range(1, 16), $urandom_range(1, 8),
                          1'b1, sent);
            done_items += sent;
        end
        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
